/* rtl/f2dt_pkg.sv */
// package: shared types, constants and power-of-ten table for fixed_to_decimal_text
`timescale 1ns / 1ps
`default_nettype none

package f2dt_pkg;

    localparam int unsigned REM_W       = 30;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned CHAR_W      = 6;

    localparam logic [13:0] DEC_SCALE    = 14'd15259;
    localparam logic [3:0]  FRACT_DIGITS = 4'd9;

    // index of the first integer digit (10000) and of the ones digit in the table
    localparam logic [IDX_W-1:0] IDX_INT_FIRST = 4'd4;
    localparam logic [IDX_W-1:0] IDX_ONES      = 4'd8;

    localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CH_POINT = 6'd46;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [IDX_W-1:0] idx;
        logic [1:0]       k;
    } t_dig_req;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             bit_set;
    } t_dig_rsp;

    // 10^(8-idx): fraction digits use 0..8, integer digits 4..8
    function automatic logic [REM_W-1:0] pow10(input logic [IDX_W-1:0] idx);
        logic [REM_W-1:0] p;
        unique case (idx)
            4'd0:    p = 30'd100000000;
            4'd1:    p = 30'd10000000;
            4'd2:    p = 30'd1000000;
            4'd3:    p = 30'd100000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd1000;
            4'd6:    p = 30'd100;
            4'd7:    p = 30'd10;
            default: p = 30'd1;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

/* rtl/f2dt_digit_unit.sv */
// shared compare and subtract unit: one binary digit bit per use
`timescale 1ns / 1ps
`default_nettype none

module f2dt_digit_unit
    import f2dt_pkg::*;
(
    input  var t_dig_req i_req,
    output var t_dig_rsp o_rsp
);

    logic [REM_W-1:0] cand;
    logic             fits;

    // power of ten times 8, 4, 2 or 1; 8e8 still fits the remainder width
    assign cand = pow10(i_req.idx) << i_req.k;
    assign fits = (i_req.rem >= cand);

    always_comb begin
        o_rsp.bit_set = fits;
        o_rsp.rem     = fits ? (i_req.rem - cand) : i_req.rem;
    end

endmodule

`default_nettype wire

/* rtl/fixed_to_decimal_text.sv */
// top level: signed 16.16 fixed-point word to ascii decimal text, one character per beat
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input: drive i_value and i_digits_after_point and raise start; the beat is taken
//   at a rising edge with start high and busy low. busy stays high until the last
//   character of that number has been issued.
//   Output: each character appears on o_character with o_valid high for exactly one
//   cycle; o_last marks the final character. The receiver cannot stall the block.
//   Sequence: one shared compare/subtract unit settles one bit of a decimal digit per
//   cycle. Per number: a sign state emits '-' when negative, then the five integer
//   digits are worked through (leading zeros are worked through but emit nothing),
//   a state emits '.', then with N > 0 fraction digits a load state forms the scaled
//   fraction and the N digits follow. busy drops in the cycle the last character
//   is shown, so the next number can be taken right then; a new number is not taken
//   while one is still in progress.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle and clears the
//   strobe; a number in progress is dropped.

module fixed_to_decimal_text
    import f2dt_pkg::*;
(
    input  var logic                     i_clk,
    input  var logic                     i_rst_n,
    input  var logic                     start,
    input  var logic signed [31:0]       i_value,
    input  var logic [3:0]               i_digits_after_point,
    output var logic                     busy,
    output var logic                     o_valid,
    output var logic [CHAR_W-1:0]        o_character,
    output var logic                     o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIGN,
        S_INT,
        S_DOT,
        S_LOAD,
        S_FRAC
    } t_state;

    t_state           r_state, n_state;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [15:0]      r_frac, n_frac;
    logic [3:0]       r_ndig, n_ndig;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [1:0]       r_k, n_k;
    logic [3:0]       r_digit, n_digit;
    logic             r_started, n_started;
    logic             r_valid, n_valid;
    logic [CHAR_W-1:0] r_char, n_char;
    logic             r_last, n_last;

    t_dig_req         req;
    t_dig_rsp         rsp;
    logic [3:0]       full_digit;
    logic [CHAR_W-1:0] digit_char;

    logic [15:0]      in_hi, in_frac, in_mag, in_frac_adj;
    logic             in_neg, in_frac_nz;

    f2dt_digit_unit u_digit (
        .i_req (req),
        .o_rsp (rsp)
    );

    assign req.rem = r_rem;
    assign req.idx = r_idx;
    assign req.k   = r_k;

    assign full_digit = {r_digit[3:1], rsp.bit_set};
    assign digit_char = CH_ZERO + {2'b00, full_digit};

    assign in_hi       = i_value[31:16];
    assign in_frac     = i_value[15:0];
    assign in_neg      = i_value[31];
    assign in_frac_nz  = (in_frac != 16'd0);
    // negative: magnitude of integer part is -hi, less 1 when a fraction is present
    assign in_mag      = !in_neg ? in_hi : (in_frac_nz ? ~in_hi : (~in_hi + 16'd1));
    assign in_frac_adj = (in_neg && in_frac_nz) ? (16'd0 - in_frac) : in_frac;

    always_comb begin
        n_state   = r_state;
        n_rem     = r_rem;
        n_frac    = r_frac;
        n_ndig    = r_ndig;
        n_idx     = r_idx;
        n_k       = r_k;
        n_digit   = r_digit;
        n_started = r_started;
        n_valid   = 1'b0;
        n_char    = r_char;
        n_last    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_rem     = {{(REM_W-16){1'b0}}, in_mag};
                    n_frac    = in_frac_adj;
                    n_ndig    = (i_digits_after_point > FRACT_DIGITS) ? FRACT_DIGITS
                                                                      : i_digits_after_point;
                    n_idx     = IDX_INT_FIRST;
                    n_k       = 2'd3;
                    n_digit   = 4'd0;
                    n_started = 1'b0;
                    n_state   = in_neg ? S_SIGN : S_INT;
                end
            end
            S_SIGN: begin
                n_valid = 1'b1;
                n_char  = CH_MINUS;
                n_state = S_INT;
            end
            S_INT: begin
                n_rem = rsp.rem;
                if (r_k != 2'd0) begin
                    n_digit[r_k] = rsp.bit_set;
                    n_k          = r_k - 2'd1;
                end else begin
                    // leading zeros are skipped, the ones digit always shows
                    if (full_digit != 4'd0 || r_started || r_idx == IDX_ONES) begin
                        n_valid   = 1'b1;
                        n_char    = digit_char;
                        n_started = 1'b1;
                    end
                    n_k     = 2'd3;
                    n_digit = 4'd0;
                    if (r_idx == IDX_ONES) begin
                        n_state = S_DOT;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            S_DOT: begin
                n_valid = 1'b1;
                n_char  = CH_POINT;
                if (r_ndig == 4'd0) begin
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_rem   = REM_W'(r_frac) * REM_W'(DEC_SCALE);
                n_idx   = 4'd0;
                n_k     = 2'd3;
                n_digit = 4'd0;
                n_state = S_FRAC;
            end
            S_FRAC: begin
                n_rem = rsp.rem;
                if (r_k != 2'd0) begin
                    n_digit[r_k] = rsp.bit_set;
                    n_k          = r_k - 2'd1;
                end else begin
                    n_valid = 1'b1;
                    n_char  = digit_char;
                    n_k     = 2'd3;
                    n_digit = 4'd0;
                    if (r_idx == r_ndig - 4'd1) begin
                        n_last  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_last  <= n_last;
        end
        r_rem     <= n_rem;
        r_frac    <= n_frac;
        r_ndig    <= n_ndig;
        r_idx     <= n_idx;
        r_k       <= n_k;
        r_digit   <= n_digit;
        r_started <= n_started;
        r_char    <= n_char;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    // the final beat of a number coincides with the return to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy)
        else $error("last character shown while still busy");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("non-final character shown after sequencer went idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted number did not start the sequencer");

    // remainder stays below ten units of the current digit weight
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INT || r_state == S_FRAC) |->
            ({2'b00, r_rem} < (32'(pow10(r_idx)) * 32'd10)))
        else $error("digit remainder out of range");

    a_strobe_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid)
        else $error("last mark without strobe");

endmodule

`default_nettype wire
